// File: sv/p2i_pkg.sv
// Shared widths, register codes, types and helpers for the plane-to-image projection.
package p2i_pkg;

  localparam int COORD_W   = 24;
  localparam int HF_W      = 21;
  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 3;
  localparam int TAN_W     = 2 * HF_W;
  localparam int PAIR_W    = 2 * COORD_W;
  localparam int H_W       = 47;
  localparam int DIV_W     = H_W + 1;
  localparam int Q_W       = 22;
  localparam int NSTEP     = Q_W;
  localparam int XN_W      = Q_W + 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_H_ROW0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_ROW1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_ROW2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL   = 3'd6;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    logic zbad;
    logic neg_x;
    logic neg_y;
    logic clamp_x;
    logic clamp_y;
  } div_tag_t;

  // Signed 21-bit field k of a packed coefficient register
  function automatic logic signed [HF_W-1:0] coef_field(input logic [CFG_W-1:0] v,
                                                       input logic [1:0] k);
    coef_field = v[HF_W*k +: HF_W];
  endfunction

endpackage

// File: sv/p2i_div.sv
// Pipelined restoring divider: one quotient bit per stage for the x and y lanes.
module p2i_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  p2i_pkg::div_tag_t          in_tag,
  input  logic [p2i_pkg::DIV_W-1:0]  in_ax,
  input  logic [p2i_pkg::DIV_W-1:0]  in_ay,
  input  logic [p2i_pkg::DIV_W-1:0]  in_d,
  output logic                       out_valid,
  output p2i_pkg::div_tag_t          out_tag,
  output logic [p2i_pkg::Q_W-1:0]    out_qx,
  output logic [p2i_pkg::Q_W-1:0]    out_qy
);
  import p2i_pkg::*;

  logic             v_r   [NSTEP];
  div_tag_t         tag_r [NSTEP];
  logic [DIV_W-1:0] rx_r  [NSTEP];
  logic [DIV_W-1:0] ry_r  [NSTEP];
  logic [DIV_W-1:0] d_r   [NSTEP];
  logic [Q_W-1:0]   qx_r  [NSTEP];
  logic [Q_W-1:0]   qy_r  [NSTEP];

  logic             v_in   [NSTEP];
  div_tag_t         tag_in [NSTEP];
  logic [DIV_W-1:0] rx_in  [NSTEP];
  logic [DIV_W-1:0] ry_in  [NSTEP];
  logic [DIV_W-1:0] d_in   [NSTEP];
  logic [Q_W-1:0]   qx_in  [NSTEP];
  logic [Q_W-1:0]   qy_in  [NSTEP];
  logic [DIV_W:0]   sx_nxt [NSTEP];
  logic [DIV_W:0]   sy_nxt [NSTEP];

  // One compare-subtract; first step tests twice the divisor, the second tests the divisor, later ones shift first
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] r,
                                              input logic [DIV_W-1:0] d,
                                              input logic first,
                                              input logic shift);
    logic [DIV_W-1:0] rs;
    logic [DIV_W-1:0] ds;
    rs = shift ? {r[DIV_W-2:0], 1'b0} : r;
    ds = first ? {d[DIV_W-2:0], 1'b0} : d;
    if (rs >= ds) begin
      div_step = {1'b1, rs - ds};
    end else begin
      div_step = {1'b0, rs};
    end
  endfunction

  // Stage inputs and step results
  always_comb begin
    v_in[0]   = in_valid;
    tag_in[0] = in_tag;
    rx_in[0]  = in_ax;
    ry_in[0]  = in_ay;
    d_in[0]   = in_d;
    qx_in[0]  = '0;
    qy_in[0]  = '0;
    for (int k = 1; k < NSTEP; k++) begin
      v_in[k]   = v_r[k-1];
      tag_in[k] = tag_r[k-1];
      rx_in[k]  = rx_r[k-1];
      ry_in[k]  = ry_r[k-1];
      d_in[k]   = d_r[k-1];
      qx_in[k]  = qx_r[k-1];
      qy_in[k]  = qy_r[k-1];
    end
    for (int k = 0; k < NSTEP; k++) begin
      sx_nxt[k] = div_step(rx_in[k], d_in[k], k == 0, k >= 2);
      sy_nxt[k] = div_step(ry_in[k], d_in[k], k == 0, k >= 2);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTEP; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NSTEP; k++) v_r[k] <= v_in[k];
    end
  end

  // Remainders, quotients and sideband
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTEP; k++) begin
        tag_r[k] <= tag_in[k];
        d_r[k]   <= d_in[k];
        rx_r[k]  <= sx_nxt[k][DIV_W-1:0];
        ry_r[k]  <= sy_nxt[k][DIV_W-1:0];
        qx_r[k]  <= {qx_in[k][Q_W-2:0], sx_nxt[k][DIV_W]};
        qy_r[k]  <= {qy_in[k][Q_W-2:0], sy_nxt[k][DIV_W]};
      end
    end
  end

  assign out_valid = v_r[NSTEP-1];
  assign out_tag   = tag_r[NSTEP-1];
  assign out_qx    = qx_r[NSTEP-1];
  assign out_qy    = qy_r[NSTEP-1];

endmodule

// File: sv/plane_to_image_projection.sv
// A word accepted on the input passes the input reg, 36 more stages and the out reg before it shows on out_tvalid.
// Throughput: one word per clock while not stalled; the stage count is set by the 22-step divide, one bit a stage.
// A two-entry output buffer (out register and skid) keeps input open while a result waits.
// The whole pipeline stalls only while the skid entry is full.
// Reset (rst_n, synchronous, active low) clears all valid bits and the configuration registers.
// Registers are taken on any cfg_valid; cfg_ready is always high.
module plane_to_image_projection (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [p2i_pkg::PAIR_W-1:0]     in_tdata,   // plane_x [23:0], plane_y [47:24]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [p2i_pkg::PAIR_W-1:0]     out_tdata,  // image_x [23:0], image_y [47:24]
  output logic                           out_tuser,  // invalid [0]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [p2i_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [p2i_pkg::CFG_W-1:0]      cfg_data
);
  import p2i_pkg::*;

  localparam int SAT_W = 47;
  localparam logic signed [SAT_W-1:0] CMAX = SAT_W'(2**(COORD_W-1) - 1);
  localparam logic signed [SAT_W-1:0] CMIN = -CMAX - SAT_W'(1);
  localparam logic signed [36:0] CD_ONE = 37'sd1048576;
  localparam logic [Q_W-1:0] NLIMIT = Q_W'(2**21);

  logic en;

  // ---------------- configuration registers
  logic [CFG_W-1:0]  h_r [3];
  logic [CFG_W-1:0]  rad_r;
  logic [TAN_W-1:0]  tan_r;
  logic [PAIR_W-1:0] foc_r;
  logic [PAIR_W-1:0] pp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) h_r[i] <= '0;
      rad_r <= '0;
      tan_r <= '0;
      foc_r <= '0;
      pp_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_H_ROW0:     h_r[0] <= cfg_data;
        REG_H_ROW1:     h_r[1] <= cfg_data;
        REG_H_ROW2:     h_r[2] <= cfg_data;
        REG_RADIAL:     rad_r  <= cfg_data;
        REG_TANGENTIAL: tan_r  <= cfg_data[TAN_W-1:0];
        REG_FOCAL:      foc_r  <= cfg_data[PAIR_W-1:0];
        REG_PRINCIPAL:  pp_r   <= cfg_data[PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient unpacking
  logic signed [HF_W-1:0] hm [3][3];
  logic signed [HF_W-1:0] k1, k2, k3, p1, p2;
  logic signed [COORD_W:0] fxs, fys;
  logic [COORD_W-1:0] cx, cy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) hm[i][j] = coef_field(h_r[i], 2'(j));
    end
    k1  = coef_field(rad_r, 2'd0);
    k2  = coef_field(rad_r, 2'd1);
    k3  = coef_field(rad_r, 2'd2);
    p1  = coef_field({{HF_W{1'b0}}, tan_r}, 2'd0);
    p2  = coef_field({{HF_W{1'b0}}, tan_r}, 2'd1);
    fxs = $signed({1'b0, foc_r[COORD_W-1:0]});
    fys = $signed({1'b0, foc_r[PAIR_W-1:COORD_W]});
    cx  = pp_r[COORD_W-1:0];
    cy  = pp_r[PAIR_W-1:COORD_W];
  end

  // ---------------- front stages: input, products, sums, divide setup
  logic sv_r [4];
  logic signed [COORD_W-1:0] px_r, py_r;
  logic signed [44:0] prx_r [3];
  logic signed [44:0] pry_r [3];
  logic signed [44:0] prx_nxt [3];
  logic signed [44:0] pry_nxt [3];
  logic signed [H_W-1:0] hs_r [3];
  logic signed [H_W-1:0] hs_nxt [3];
  logic signed [30:0] tsc [3];
  logic [DIV_W-1:0] ax_r, ay_r, dz_r, ax_nxt, ay_nxt, dz_nxt;
  div_tag_t tag_r, tag_nxt;
  logic signed [H_W:0] xe, ye;

  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prx_nxt[i] = hm[i][0] * px_r;
      pry_nxt[i] = hm[i][1] * py_r;
      tsc[i]     = $signed({hm[i][2], 10'b0});
      hs_nxt[i]  = prx_r[i] + pry_r[i] + tsc[i];
    end
    // magnitudes, divisor check and far-off-axis clamp
    xe = hs_r[0];
    ye = hs_r[1];
    ax_nxt = xe[H_W] ? -xe : xe;
    ay_nxt = ye[H_W] ? -ye : ye;
    dz_nxt = DIV_W'(hs_r[2]);
    tag_nxt.zbad    = hs_r[2][H_W-1] || (hs_r[2] == '0);
    tag_nxt.neg_x   = xe[H_W];
    tag_nxt.neg_y   = ye[H_W];
    tag_nxt.clamp_x = ax_nxt > {dz_nxt[DIV_W-2:0], 1'b0};
    tag_nxt.clamp_y = ay_nxt > {dz_nxt[DIV_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) sv_r[k] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= in_tvalid;
      for (int k = 1; k < 4; k++) sv_r[k] <= sv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= in_tdata[COORD_W-1:0];
      py_r <= in_tdata[PAIR_W-1:COORD_W];
      for (int i = 0; i < 3; i++) begin
        prx_r[i] <= prx_nxt[i];
        pry_r[i] <= pry_nxt[i];
        hs_r[i]  <= hs_nxt[i];
      end
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      dz_r  <= dz_nxt;
      tag_r <= tag_nxt;
    end
  end

  // ---------------- perspective divide
  logic dv;
  div_tag_t dtag;
  logic [Q_W-1:0] dqx, dqy;

  p2i_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sv_r[3]),
    .in_tag   (tag_r),
    .in_ax    (ax_r),
    .in_ay    (ay_r),
    .in_d     (dz_r),
    .out_valid(dv),
    .out_tag  (dtag),
    .out_qx   (dqx),
    .out_qy   (dqy)
  );

  // ---------------- distortion and scaling stages E0..E10
  logic ev_r  [11];
  logic zb_r  [11];
  logic bad_r [10];
  logic signed [XN_W-1:0] xn_r [7];
  logic signed [XN_W-1:0] yn_r [7];
  logic [Q_W-1:0] mx, my;
  logic signed [XN_W-1:0] xn_nxt, yn_nxt;

  // E0: clamp and sign
  always_comb begin
    mx = dtag.clamp_x ? NLIMIT : dqx;
    my = dtag.clamp_y ? NLIMIT : dqy;
    xn_nxt = dtag.neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    yn_nxt = dtag.neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
  end

  // E1: squares and cross term
  logic signed [45:0] pxx, pyy, pxy;
  logic signed [23:0] x2_r, y2_r, xy_r;
  assign pxx = xn_r[0] * xn_r[0];
  assign pyy = yn_r[0] * yn_r[0];
  assign pxy = xn_r[0] * yn_r[0];

  // E2: radius and tangential arguments
  logic signed [24:0] r2_nxt, a1_nxt;
  logic signed [25:0] a2_nxt, a3_nxt;
  logic signed [24:0] r2_r, r2b_r, a1_r;
  logic signed [25:0] a2_r, a3_r;
  always_comb begin
    r2_nxt = x2_r + y2_r;
    a1_nxt = xy_r <<< 1;
    a2_nxt = r2_nxt + (x2_r <<< 1);
    a3_nxt = r2_nxt + (y2_r <<< 1);
  end

  // E3: r^4, k1*r^2 and the four tangential products
  logic signed [49:0] pr4;
  logic signed [27:0] r4_r;
  logic signed [45:0] k1r2_r, k1r2b_r;
  logic signed [46:0] pt_r [4];
  assign pr4 = r2_r * r2_r;

  // E4: r^6, k2*r^4, tangential sums
  logic signed [52:0] pr6;
  logic signed [47:0] tsx, tsy;
  logic signed [30:0] r6_r;
  logic signed [48:0] k2r4_r;
  logic signed [30:0] tx_r [4];
  logic signed [30:0] ty_r [4];
  assign pr6 = r4_r * r2b_r;
  assign tsx = pt_r[0] + pt_r[1];
  assign tsy = pt_r[2] + pt_r[3];

  // E5: k3*r^6 and the sum k1*r^2 + k2*r^4
  logic signed [51:0] k3r6_r;
  logic signed [49:0] k12_r;

  // E6: radial factor
  logic signed [52:0] ks;
  logic signed [36:0] cd_r;
  assign ks = k12_r + k3r6_r;

  // E7: split products of the normalized point by the radial factor
  logic signed [40:0] pxl_r, pyl_r;
  logic signed [42:0] pxh_r, pyh_r;

  // E8: distorted point
  logic signed [59:0] xcd, ycd;
  logic signed [40:0] xd_r, yd_r;
  assign xcd = (pxh_r <<< 17) + pxl_r;
  assign ycd = (pyh_r <<< 17) + pyl_r;

  // E9: split focal products
  logic signed [44:0] pfxl_r, pfyl_r;
  logic signed [46:0] pfxh_r, pfyh_r;

  // E10: principal point, rounding and saturation
  logic signed [66:0] fullx, fully;
  logic signed [SAT_W-1:0] ixw, iyw;
  logic [COORD_W-1:0] imgx_nxt, imgy_nxt, imgx_r, imgy_r;
  logic ovx, ovy, inv_nxt, inv_r;
  always_comb begin
    fullx = (pfxh_r <<< 19) + pfxl_r + $signed({1'b0, cx, 20'b0});
    fully = (pfyh_r <<< 19) + pfyl_r + $signed({1'b0, cy, 20'b0});
    ixw = $signed(fullx[66:20]);
    iyw = $signed(fully[66:20]);
    ovx = (ixw > CMAX) || (ixw < CMIN);
    ovy = (iyw > CMAX) || (iyw < CMIN);
    imgx_nxt = (ixw > CMAX) ? CMAX[COORD_W-1:0] :
               (ixw < CMIN) ? CMIN[COORD_W-1:0] : ixw[COORD_W-1:0];
    imgy_nxt = (iyw > CMAX) ? CMAX[COORD_W-1:0] :
               (iyw < CMIN) ? CMIN[COORD_W-1:0] : iyw[COORD_W-1:0];
    inv_nxt = bad_r[9] || ovx || ovy;
    // zero or negative divisor
    if (zb_r[9]) begin
      imgx_nxt = '0;
      imgy_nxt = '0;
      inv_nxt  = 1'b1;
    end
  end

  // Valid bits of E0..E10
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 11; k++) ev_r[k] <= 1'b0;
    end else if (en) begin
      ev_r[0] <= dv;
      for (int k = 1; k < 11; k++) ev_r[k] <= ev_r[k-1];
    end
  end

  // Data of E0..E10
  always_ff @(posedge clk) begin
    if (en) begin
      zb_r[0]  <= dtag.zbad;
      bad_r[0] <= dtag.clamp_x || dtag.clamp_y;
      for (int k = 1; k < 11; k++) zb_r[k] <= zb_r[k-1];
      for (int k = 1; k < 10; k++) bad_r[k] <= bad_r[k-1];
      xn_r[0] <= xn_nxt;
      yn_r[0] <= yn_nxt;
      for (int k = 1; k < 7; k++) begin
        xn_r[k] <= xn_r[k-1];
        yn_r[k] <= yn_r[k-1];
      end
      // E1
      x2_r <= pxx[43:20];
      y2_r <= pyy[43:20];
      xy_r <= pxy[43:20];
      // E2
      r2_r <= r2_nxt;
      a1_r <= a1_nxt;
      a2_r <= a2_nxt;
      a3_r <= a3_nxt;
      // E3
      r2b_r   <= r2_r;
      r4_r    <= pr4[47:20];
      k1r2_r  <= k1 * r2_r;
      pt_r[0] <= p1 * a1_r;
      pt_r[1] <= p2 * a2_r;
      pt_r[2] <= p1 * a3_r;
      pt_r[3] <= p2 * a1_r;
      // E4
      r6_r    <= pr6[50:20];
      k2r4_r  <= k2 * r4_r;
      k1r2b_r <= k1r2_r;
      tx_r[0] <= tsx[47:17];
      ty_r[0] <= tsy[47:17];
      for (int k = 1; k < 4; k++) begin
        tx_r[k] <= tx_r[k-1];
        ty_r[k] <= ty_r[k-1];
      end
      // E5
      k3r6_r <= k3 * r6_r;
      k12_r  <= k1r2b_r + k2r4_r;
      // E6
      cd_r <= CD_ONE + $signed(ks[52:17]);
      // E7
      pxl_r <= xn_r[6] * $signed({1'b0, cd_r[16:0]});
      pxh_r <= xn_r[6] * $signed(cd_r[36:17]);
      pyl_r <= yn_r[6] * $signed({1'b0, cd_r[16:0]});
      pyh_r <= yn_r[6] * $signed(cd_r[36:17]);
      // E8
      xd_r <= $signed(xcd[59:20]) + tx_r[3];
      yd_r <= $signed(ycd[59:20]) + ty_r[3];
      // E9
      pfxl_r <= $signed({1'b0, xd_r[18:0]}) * fxs;
      pfxh_r <= $signed(xd_r[40:19]) * fxs;
      pfyl_r <= $signed({1'b0, yd_r[18:0]}) * fys;
      pfyh_r <= $signed(yd_r[40:19]) * fys;
      // E10
      imgx_r <= imgx_nxt;
      imgy_r <= imgy_nxt;
      inv_r  <= inv_nxt;
    end
  end

  // ---------------- output register with skid entry
  logic out_v_r, skid_v_r;
  logic [PAIR_W-1:0] out_d_r, skid_d_r;
  logic out_u_r, skid_u_r;

  assign en = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (ev_r[10] && en) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= ev_r[10];
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (en) begin
        skid_d_r <= {imgy_r, imgx_r};
        skid_u_r <= inv_r;
      end
    end else if (skid_v_r) begin
      out_d_r <= skid_d_r;
      out_u_r <= skid_u_r;
    end else begin
      out_d_r <= {imgy_r, imgx_r};
      out_u_r <= inv_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while output register empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready && ev_r[10]))
    else $error("skid entry filled without a blocked output");

  a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_r[10] && zb_r[10]) |-> (imgx_r == '0 && imgy_r == '0 && inv_r))
    else $error("non-positive divisor did not give a zero invalid result");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the plane-to-image projection pipeline.
`timescale 1ns / 100ps

module testbench;
  import p2i_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY = 40;

  typedef struct packed {
    logic        invalid;
    logic [23:0] image_y;
    logic [23:0] image_x;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [PAIR_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [PAIR_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  plane_to_image_projection dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the camera registers
  logic [62:0] cam_h0, cam_h1, cam_h2, cam_rad;
  logic [41:0] cam_tan;
  logic [47:0] cam_focal, cam_pp;

  pixel_t pixel_queue[$];
  int mismatches = 0;
  int points_sent = 0;
  int pixels_seen = 0;
  int invalid_seen = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint coef(input logic [62:0] r, input int k);
    logic signed [20:0] f;
    f = r[21*k +: 21];
    return longint'(f);
  endfunction

  function automatic longint floor_shift(input longint v, input int n);
    return v >>> n;  // arithmetic shift is floor
  endfunction

  function automatic longint divide_q20(input longint num, input longint den, inout bit bad);
    longint a, q, r;
    a = (num < 0) ? -num : num;
    if (a > 2 * den) begin
      bad = 1;
      q = 64'sd1 << 21;
    end else begin
      q = a / den;
      r = a - q * den;
      for (int i = 0; i < 20; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
    end
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_coord(input longint v, inout bit bad);
    if (v > 64'sd8388607) begin
      bad = 1;
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      bad = 1;
      return -64'sd8388608;
    end
    return v;
  endfunction

  function automatic pixel_t project_point(input logic [23:0] px_raw, input logic [23:0] py_raw);
    longint px, py, hx, hy, hz, xn, yn, x2, y2, xy, r2, r4, r6, cd, a1, a2, a3, xd, yd, ix, iy;
    bit bad;
    pixel_t p;
    bad = 0;
    px = longint'($signed(px_raw));
    py = longint'($signed(py_raw));
    hx = coef(cam_h0, 0) * px + coef(cam_h0, 1) * py + coef(cam_h0, 2) * 1024;
    hy = coef(cam_h1, 0) * px + coef(cam_h1, 1) * py + coef(cam_h1, 2) * 1024;
    hz = coef(cam_h2, 0) * px + coef(cam_h2, 1) * py + coef(cam_h2, 2) * 1024;
    if (hz <= 0) begin
      p = '0;
      p.invalid = 1'b1;
      return p;
    end
    xn = divide_q20(hx, hz, bad);
    yn = divide_q20(hy, hz, bad);
    x2 = floor_shift(xn * xn, 20);
    y2 = floor_shift(yn * yn, 20);
    xy = floor_shift(xn * yn, 20);
    r2 = x2 + y2;
    r4 = floor_shift(r2 * r2, 20);
    r6 = floor_shift(r4 * r2, 20);
    cd = (64'sd1 << 20) + floor_shift(coef(cam_rad, 0) * r2 + coef(cam_rad, 1) * r4 +
                                      coef(cam_rad, 2) * r6, 17);
    a1 = 2 * xy;
    a2 = r2 + 2 * x2;
    a3 = r2 + 2 * y2;
    xd = floor_shift(xn * cd, 20) +
         floor_shift(coef({21'd0, cam_tan}, 0) * a1 + coef({21'd0, cam_tan}, 1) * a2, 17);
    yd = floor_shift(yn * cd, 20) +
         floor_shift(coef({21'd0, cam_tan}, 0) * a3 + coef({21'd0, cam_tan}, 1) * a1, 17);
    ix = floor_shift(xd * longint'(cam_focal[23:0]) + (longint'(cam_pp[23:0]) << 20), 20);
    iy = floor_shift(yd * longint'(cam_focal[47:24]) + (longint'(cam_pp[47:24]) << 20), 20);
    ix = clamp_coord(ix, bad);
    iy = clamp_coord(iy, bad);
    p.image_x = ix[23:0];
    p.image_y = iy[23:0];
    p.invalid = bad;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch at pixel %0d: %s got %0h expected %0h", pixels_seen, what, got, want);
  endtask

  // Result checker and output stall generator
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch("unexpected word", longint'(out_tdata), 64'sd0);
      end else begin
        want = pixel_queue.pop_front();
        if (out_tdata[23:0] !== want.image_x)
          report_mismatch("image_x", longint'(out_tdata[23:0]), longint'(want.image_x));
        if (out_tdata[47:24] !== want.image_y)
          report_mismatch("image_y", longint'(out_tdata[47:24]), longint'(want.image_y));
        if (out_tuser !== want.invalid)
          report_mismatch("invalid", longint'(out_tuser), longint'(want.invalid));
        if (want.invalid) invalid_seen++;
      end
      pixels_seen++;
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_point(input logic [23:0] px, input logic [23:0] py);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixel_queue.push_back(project_point(px, py));
    points_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pixel_queue.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [62:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_H_ROW0: cam_h0 = val;
      REG_H_ROW1: cam_h1 = val;
      REG_H_ROW2: cam_h2 = val;
      REG_RADIAL: cam_rad = val;
      REG_TANGENTIAL: cam_tan = val[41:0];
      REG_FOCAL: cam_focal = val[47:0];
      REG_PRINCIPAL: cam_pp = val[47:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [62:0] pack3(input int a, input int b, input int c);
    return {c[20:0], b[20:0], a[20:0]};
  endfunction

  // Typical camera: identity-like homography with tz, mild distortion
  task automatic load_camera(input int scale);
    write_reg(REG_H_ROW0, pack3(4096 * scale, $urandom_range(400) - 200, $urandom_range(8000) - 4000));
    write_reg(REG_H_ROW1, pack3($urandom_range(400) - 200, 4096 * scale, $urandom_range(8000) - 4000));
    write_reg(REG_H_ROW2, pack3($urandom_range(60) - 30, $urandom_range(60) - 30, 4096 * 64));
    write_reg(REG_RADIAL, pack3($urandom_range(40000) - 20000, $urandom_range(10000) - 5000,
                                $urandom_range(4000) - 2000));
    write_reg(REG_TANGENTIAL, pack3($urandom_range(2000) - 1000,
                                    $urandom_range(2000) - 1000, 0));
    write_reg(REG_FOCAL, 63'({24'(800 << 10), 24'(800 << 10)}));
    write_reg(REG_PRINCIPAL, 63'({24'(240 << 10), 24'(320 << 10)}));
  endtask

  task automatic test_reset_values();
    // all registers zero: divisor zero, every point invalid
    send_point(24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h800000);
    drain_pipeline();
  endtask

  task automatic test_directed_extremes();
    load_camera(1);
    send_point(24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h800000);
    send_point(24'h000400, 24'hfffc00);
    send_point(24'h00a000, 24'h005000);
    send_point(24'hff6000, 24'h00a000);
    drain_pipeline();
    // far off axis: clamp at two
    write_reg(REG_H_ROW0, pack3(1048575, 0, 1048575));
    send_point(24'h100000, 24'h000000);
    send_point(24'hf00000, 24'h000000);
    // negative divisor
    drain_pipeline();
    write_reg(REG_H_ROW2, pack3(0, 0, -4096));
    send_point(24'h000100, 24'h000100);
    drain_pipeline();
    // extreme registers: all ones / all set
    write_reg(REG_H_ROW0, '1);
    write_reg(REG_H_ROW1, pack3(-1048576, -1048576, 1048575));
    write_reg(REG_H_ROW2, pack3(0, 0, 1048575));
    write_reg(REG_RADIAL, pack3(1048575, -1048576, 1048575));
    write_reg(REG_TANGENTIAL, pack3(-1048576, 1048575, 0));
    write_reg(REG_FOCAL, '1);
    write_reg(REG_PRINCIPAL, '1);
    send_point(24'h123456, 24'hedcba9);
    send_point(24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h000001);
    drain_pipeline();
    write_reg(REG_FOCAL, '0);
    write_reg(REG_PRINCIPAL, '0);
    send_point(24'h000000, 24'h000000);
    drain_pipeline();
  endtask

  task automatic run_points(input int n, input int range_q);
    logic [23:0] px, py;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        px = 24'($urandom);
        py = 24'($urandom);
      end else begin
        px = 24'($urandom_range(2 * range_q) - range_q);
        py = 24'($urandom_range(2 * range_q) - range_q);
      end
      send_point(px, py);
    end
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int scale);
    idle_pct = idle;
    stall_pct = stall;
    load_camera(scale);
    run_points(200, 20000 * scale);
    // hold off until the pipeline is empty, then continue
    while (pixel_queue.size() != 0) @(negedge clk);
    run_points(160, 60000);
    drain_pipeline();
  endtask

  task automatic test_random_registers();
    idle_pct = 30;
    stall_pct = 30;
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_H_ROW0, 63'({$urandom, $urandom}));
      write_reg(REG_H_ROW1, 63'({$urandom, $urandom}));
      write_reg(REG_H_ROW2, 63'({$urandom, $urandom}));
      write_reg(REG_RADIAL, 63'({$urandom, $urandom}));
      write_reg(REG_TANGENTIAL, 63'({$urandom, $urandom}));
      write_reg(REG_FOCAL, 63'({$urandom, $urandom}));
      write_reg(REG_PRINCIPAL, 63'({$urandom, $urandom}));
      run_points(40, 8388607);
      drain_pipeline();
    end
  endtask

  initial begin
    cam_h0 = '0; cam_h1 = '0; cam_h2 = '0; cam_rad = '0;
    cam_tan = '0; cam_focal = '0; cam_pp = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_directed_extremes();
    test_random_phase(0, 0, 1);
    test_random_phase(82, 0, 2);
    test_random_phase(0, 82, 1);
    test_random_phase(30, 30, 4);
    test_random_registers();
    $display("sent %0d points, checked %0d pixels (%0d flagged invalid)",
             points_sent, pixels_seen, invalid_seen);
    $display("covered reset registers, clamps, bad divisors, saturation and stall mixes");
    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/p2i_pkg.sv
sv/p2i_div.sv
sv/plane_to_image_projection.sv
tb/sv/testbench.sv
